### rtl/gtht_pkg.sv
package gtht_pkg;

  localparam int MAX_GROUPS_DEF  = 64;
  localparam int GROUP_SLOTS     = 16;
  localparam int SLOT_BITS       = 4;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  localparam logic [7:0] CTRL_EMPTY   = 8'h80;
  localparam logic [7:0] CTRL_DELETED = 8'hFE;
  localparam logic [6:0] TAG_MASK     = 7'h7F;

  localparam logic [6:0]  GROUP_COUNT_RESET = 7'd2;
  localparam logic [10:0] LOAD_LIMIT_RESET  = 11'd22;
  localparam logic [10:0] COUNT_MAX         = 11'h7FF;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SPARE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_SPARE    = 2'd3
  } status_t;

  typedef enum logic {
    REG_GROUP_COUNT = 1'b0,
    REG_LOAD_LIMIT  = 1'b1
  } reg_index_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [6:0]  divisor;
  } mod_ctl_t;

  // Answer from the remainder unit.
  typedef struct packed {
    logic       done;
    logic [6:0] remainder;
  } mod_sts_t;

endpackage

### rtl/gtht_req_if.sv
interface gtht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] hash;
  logic [31:0] key;
  logic [31:0] value;

  modport source (output valid, action, hash, key, value, input ready);
  modport sink (input valid, action, hash, key, value, output ready);
endinterface

### rtl/gtht_rsp_if.sv
interface gtht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [31:0] stored_key;
  logic [9:0]  slot_index;

  modport source (output valid, status, found_value, stored_key, slot_index, input ready);
  modport sink (input valid, status, found_value, stored_key, slot_index, output ready);
endinterface

### rtl/gtht_mod.sv
module gtht_mod (
  input  logic              clk,
  input  logic              rst,
  input  gtht_pkg::mod_ctl_t ctl,
  output gtht_pkg::mod_sts_t sts
);
  import gtht_pkg::*;

  // Restoring remainder, eight dividend bits per cycle, MSB first.
  logic [63:0] dividend;
  logic [6:0]  divisor;
  logic [6:0]  rem;
  logic [2:0]  count;
  logic        busy;
  logic        done;
  logic [6:0]  rem_next;

  always_comb begin
    logic [7:0] r2;
    rem_next = rem;
    for (int k = 0; k < 8; k++) begin
      r2 = {rem_next, dividend[63-k]};
      if (r2 >= {1'b0, divisor}) begin
        r2 = r2 - {1'b0, divisor};
      end
      rem_next = r2[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy     <= 1'b1;
        count    <= '0;
        rem      <= '0;
        dividend <= ctl.dividend;
        divisor  <= ctl.divisor;
      end else if (busy) begin
        rem      <= rem_next;
        dividend <= {dividend[55:0], 8'h00};
        count    <= count + 3'd1;
        if (count == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.done      = done;
  assign sts.remainder = rem;
endmodule

### rtl/grouped_tag_hash_table_core.sv
// Grouped-tag open-addressing hash table. Slots sit in groups of sixteen; each
// slot has a control byte (empty, deleted, or a 7-bit tag from the low hash
// bits), a key and a value. A request transaction carries an action (lookup,
// insert or update, delete), a precomputed 64-bit hash, a key and a value, and
// produces exactly one response transaction with a status, the value found or
// removed, the key removed and the slot touched. The home group is
// (hash >> 7) mod group_count, and the probe walks groups linearly, comparing
// the tag and key on all sixteen slots of a group at once, until a hit, a group
// with an empty slot, or group_count groups. After reset the control memory is
// swept to empty, one group per cycle, and no request is taken during that
// sweep; configuration writes are accepted at any time but must only change
// while the block is idle. One request at a time is processed: it is
// accepted, the remainder unit works out the home group and its result is
// taken, each group probed takes a synchronous read of the control and key
// rows and then a compare and update, lookup and delete hits add a value
// read, and the result is handed to the response register once that register
// is empty or being taken. The next request is taken after that hand-off.
// The response register lets the next request be accepted while the previous
// response still waits to be taken.
module grouped_tag_hash_table_core #(
  parameter int MAX_GROUPS = gtht_pkg::MAX_GROUPS_DEF,
  parameter int KEY_BITS   = gtht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = gtht_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  gtht_req_if.sink    req,
  gtht_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gtht_pkg::*;

  localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SW     = GW + SLOT_BITS;
  localparam int CW     = (GW + 1 > 7) ? GW + 1 : 7;
  localparam int GC_CAP = (MAX_GROUPS > 127) ? 127 : MAX_GROUPS;
  localparam int KW     = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_ISSUE, S_EVAL, S_VREAD, S_DONE
  } state_t;

  // Configuration registers.
  logic [6:0]  group_count;
  logic [10:0] load_limit;
  logic        cfg_write;
  reg_index_t  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= GROUP_COUNT_RESET;
      load_limit  <= LOAD_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GROUP_COUNT: group_count <= pwdata[6:0];
        REG_LOAD_LIMIT:  load_limit  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_GROUP_COUNT: prdata = 32'(group_count);
      REG_LOAD_LIMIT:  prdata = 32'(load_limit);
      default:         prdata = '0;
    endcase
  end

  // Group count as used by the probe: zero acts as one, and the count is
  // clamped to the number of groups that exist.
  logic [6:0] gc_eff;
  always_comb begin
    if (group_count == 7'd0) begin
      gc_eff = 7'd1;
    end else if (group_count > 7'(GC_CAP)) begin
      gc_eff = 7'(GC_CAP);
    end else begin
      gc_eff = group_count;
    end
  end

  // Storage: control bytes and keys by group row, values by slot.
  logic [GROUP_SLOTS-1:0][7:0]    ctrl_mem  [MAX_GROUPS];
  logic [GROUP_SLOTS-1:0][KW-1:0] key_mem   [MAX_GROUPS];
  logic [VW-1:0]                  value_mem [MAX_GROUPS*GROUP_SLOTS];

  logic [GROUP_SLOTS-1:0][7:0]    ctrl_q;
  logic [GROUP_SLOTS-1:0][KW-1:0] key_q;
  logic [VW-1:0]                  val_q;

  // Request and probe registers.
  state_t          state;
  logic [GW-1:0]   clr_row;
  action_t         act;
  logic [6:0]      tag;
  logic [KW-1:0]   key_r;
  logic [VW-1:0]   val_r;
  logic [6:0]      gc_r;
  logic [GW-1:0]   grp;
  logic [CW-1:0]   probe_cnt;
  logic            del_found;
  logic [SW-1:0]   del_pos;
  logic [SW-1:0]   v_addr;
  logic [10:0]     entry_count;

  logic [1:0]      res_status;
  logic [31:0]     res_key;
  logic [9:0]      res_slot;
  logic            res_use_val;

  // Remainder unit for the home group.
  mod_ctl_t mctl;
  mod_sts_t msts;

  gtht_mod u_mod (
    .clk (clk),
    .rst (rst),
    .ctl (mctl),
    .sts (msts)
  );

  logic accept;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign mctl.start    = accept;
  assign mctl.dividend = {7'd0, req.hash[63:7]};
  assign mctl.divisor  = gc_eff;

  // Sixteen-way compare of the group row just read.
  logic [GROUP_SLOTS-1:0] hit_vec, empty_vec, del_vec;
  logic                   hit_any, empty_any, del_any;
  logic [SLOT_BITS-1:0]   hit_idx, empty_idx, del_idx;

  always_comb begin
    for (int s = 0; s < GROUP_SLOTS; s++) begin
      hit_vec[s]   = (ctrl_q[s] == {1'b0, tag}) && (key_q[s] == key_r);
      empty_vec[s] = (ctrl_q[s] == CTRL_EMPTY);
      del_vec[s]   = (ctrl_q[s] == CTRL_DELETED);
    end
    hit_idx   = '0;
    empty_idx = '0;
    del_idx   = '0;
    for (int s = GROUP_SLOTS - 1; s >= 0; s--) begin
      if (hit_vec[s])   hit_idx   = SLOT_BITS'(s);
      if (empty_vec[s]) empty_idx = SLOT_BITS'(s);
      if (del_vec[s])   del_idx   = SLOT_BITS'(s);
    end
    hit_any   = |hit_vec;
    empty_any = |empty_vec;
    del_any   = |del_vec;
  end

  // Decisions of the evaluate cycle.
  logic          probe_end;
  logic [SW-1:0] ins_pos;
  logic          ins_ok;
  logic [GW-1:0] grp_next;

  always_comb begin
    probe_end = empty_any || ((probe_cnt + CW'(1)) == CW'(gc_r));
    grp_next  = ((CW'(grp) + CW'(1)) == CW'(gc_r)) ? '0 : grp + GW'(1);
    ins_ok    = 1'b1;
    if (del_found) begin
      ins_pos = del_pos;
    end else if (del_any && (!empty_any || (del_idx < empty_idx))) begin
      ins_pos = {grp, del_idx};
    end else if (empty_any) begin
      ins_pos = {grp, empty_idx};
    end else begin
      ins_pos = '0;
      ins_ok  = 1'b0;
    end
    if (entry_count >= load_limit) begin
      ins_ok = 1'b0;
    end
  end

  // Memory write ports.
  logic          cw_en;
  logic [SW-1:0] cw_addr;
  logic [7:0]    cw_data;
  logic          kw_en;
  logic          vw_en;
  logic [SW-1:0] vw_addr;

  always_comb begin
    cw_en   = 1'b0;
    cw_addr = ins_pos;
    cw_data = {1'b0, tag};
    kw_en   = 1'b0;
    vw_en   = 1'b0;
    vw_addr = ins_pos;
    if (state == S_EVAL) begin
      if (hit_any) begin
        if (act == ACT_INSERT) begin
          vw_en   = 1'b1;
          vw_addr = {grp, hit_idx};
        end else if (act == ACT_DELETE) begin
          cw_en   = 1'b1;
          cw_addr = {grp, hit_idx};
          cw_data = CTRL_DELETED;
        end
      end else if (probe_end && act == ACT_INSERT && ins_ok) begin
        cw_en = 1'b1;
        kw_en = 1'b1;
        vw_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      ctrl_mem[clr_row] <= {GROUP_SLOTS{CTRL_EMPTY}};
    end else if (cw_en) begin
      ctrl_mem[cw_addr[SW-1:SLOT_BITS]][cw_addr[SLOT_BITS-1:0]] <= cw_data;
    end
    if (kw_en) begin
      key_mem[cw_addr[SW-1:SLOT_BITS]][cw_addr[SLOT_BITS-1:0]] <= key_r;
    end
    if (vw_en) begin
      value_mem[vw_addr] <= val_r;
    end
    ctrl_q <= ctrl_mem[grp];
    key_q  <= key_mem[grp];
    val_q  <= value_mem[v_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_row     <= '0;
      entry_count <= '0;
      rsp.valid   <= 1'b0;
      del_found   <= 1'b0;
    end else begin
      // In the hand-off state the response register is reloaded below instead.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + GW'(1);
          if (clr_row == GW'(MAX_GROUPS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act       <= action_t'(req.action);
            tag       <= req.hash[6:0] & TAG_MASK;
            key_r     <= req.key[KW-1:0];
            val_r     <= req.value[VW-1:0];
            gc_r      <= gc_eff;
            probe_cnt <= '0;
            del_found <= 1'b0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (msts.done) begin
            grp   <= GW'(msts.remainder);
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          res_use_val <= 1'b0;
          res_key     <= '0;
          res_slot    <= '0;
          if (hit_any) begin
            res_status <= ST_OK;
            res_slot   <= 10'({grp, hit_idx});
            v_addr     <= {grp, hit_idx};
            if (act == ACT_INSERT) begin
              state <= S_DONE;
            end else begin
              res_use_val <= 1'b1;
              state       <= S_VREAD;
              if (act == ACT_DELETE) begin
                res_key <= 32'(key_r);
                if (entry_count != 11'd0) begin
                  entry_count <= entry_count - 11'd1;
                end
              end
            end
          end else begin
            if (!del_found && del_any) begin
              del_found <= 1'b1;
              del_pos   <= {grp, del_idx};
            end
            if (probe_end) begin
              state <= S_DONE;
              if (act != ACT_INSERT) begin
                res_status <= ST_NOT_FOUND;
              end else if (ins_ok) begin
                res_status <= ST_OK;
                res_slot   <= 10'(ins_pos);
                if (entry_count != COUNT_MAX) begin
                  entry_count <= entry_count + 11'd1;
                end
              end else begin
                res_status <= ST_FULL;
              end
            end else begin
              grp       <= grp_next;
              probe_cnt <= probe_cnt + CW'(1);
              state     <= S_ISSUE;
            end
          end
        end
        S_VREAD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.found_value <= res_use_val ? 32'(val_q) : 32'd0;
            rsp.stored_key  <= res_key;
            rsp.slot_index  <= res_slot;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
